// ===== rtl/feedback_queue_dispatcher_defines.svh =====
// assertion macros shared by the feedback queue dispatcher rtl
// every macro samples on i_clk and is disabled while i_rst_n is low
`ifndef FEEDBACK_QUEUE_DISPATCHER_DEFINES_SVH
`define FEEDBACK_QUEUE_DISPATCHER_DEFINES_SVH

// condition holds at every edge out of reset
`define FQD_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define FQD_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent holds in the cycle after the antecedent
`define FQD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/fqd_pkg.sv =====
// shared types and constants of the feedback queue dispatcher
// no dependencies; used by the controller, datapath and top level
package fqd_pkg;

    localparam int NUM_LEVELS      = 4;
    localparam int LVL_W           = 2;
    localparam int ID_W            = 8;
    localparam int TIME_W          = 16;
    localparam int CLK_W           = 32;
    localparam int ENTRY_W         = ID_W + TIME_W;
    localparam int DEF_QUEUE_DEPTH = 16;

    localparam logic [LVL_W-1:0] TOP_LEVEL = 2'd3;
    localparam logic [LVL_W-1:0] SYS_LEVEL = 2'd0;

    localparam logic REQ_SUBMIT = 1'b0;
    localparam logic REQ_TICK   = 1'b1;

    typedef enum logic [2:0] {
        ACT_ACCEPT   = 3'd0,
        ACT_REJECT   = 3'd1,
        ACT_IDLE     = 3'd2,
        ACT_DISPATCH = 3'd3,
        ACT_CONTINUE = 3'd4,
        ACT_PREEMPT  = 3'd5,
        ACT_FINISH   = 3'd6,
        ACT_SYSDONE  = 3'd7
    } t_action;

    typedef struct packed {
        logic              req_type;
        logic [ID_W-1:0]   job_id;
        logic [LVL_W-1:0]  job_level;
        logic [TIME_W-1:0] run_time;
    } t_in_req;

    typedef struct packed {
        t_action           action;
        logic [ID_W-1:0]   out_job_id;
        logic [LVL_W-1:0]  out_level;
        logic [TIME_W-1:0] remaining_time;
        logic [CLK_W-1:0]  current_time;
    } t_out_rsp;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic exec;
        logic read_head;
        logic pop;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic is_tick;
        logic run_valid;
        logic any_waiting;
        logic out_free;
    } t_dp_status;

endpackage

// ===== rtl/fqd_datapath.sv =====
// datapath of the feedback queue dispatcher: level queues, running job, time, result register
// depends on fqd_pkg and feedback_queue_dispatcher_defines.svh
`include "feedback_queue_dispatcher_defines.svh"

module fqd_datapath import fqd_pkg::*; #(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_in_req    i_in_req,
    input  t_dp_cmd    i_cmd,
    input  logic       i_out_stall,
    output t_dp_status o_status,
    output logic       o_out_valid,
    output t_out_rsp   o_out_rsp
);

    localparam int PTR_W     = $clog2(QUEUE_DEPTH);
    localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
    localparam int ADDR_W    = LVL_W + PTR_W;
    localparam int MEM_DEPTH = NUM_LEVELS * (1 << PTR_W);

    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] ptr);
        ptr_inc = (ptr == LAST_PTR) ? '0 : ptr + 1'b1;
    endfunction

    t_in_req            r_req;
    logic [ENTRY_W-1:0] r_mem [MEM_DEPTH];
    logic [ENTRY_W-1:0] r_rd_data;
    logic [PTR_W-1:0]   r_head  [NUM_LEVELS];
    logic [PTR_W-1:0]   r_tail  [NUM_LEVELS];
    logic [CNT_W-1:0]   r_count [NUM_LEVELS];
    logic               r_run_valid;
    logic [ID_W-1:0]    r_run_id;
    logic [LVL_W-1:0]   r_run_lvl;
    logic [TIME_W-1:0]  r_run_rem;
    logic [CLK_W-1:0]   r_time;
    logic [LVL_W-1:0]   r_pop_lvl;
    logic               r_out_valid;
    t_out_rsp           r_out;

    logic               any_waiting;
    logic [LVL_W-1:0]   sel_lvl;
    logic               out_free;

    logic               w_push;
    logic [LVL_W-1:0]   w_push_lvl;
    logic [ENTRY_W-1:0] w_push_entry;
    t_out_rsp           w_rsp;
    logic               n_run_valid;
    logic [TIME_W-1:0]  n_run_rem;
    logic [TIME_W-1:0]  rem_dec;
    logic [LVL_W-1:0]   demote_lvl;

    logic [ID_W-1:0]    pop_id;
    logic [TIME_W-1:0]  pop_t;
    t_out_rsp           p_rsp;

    logic               count_ok;

    // occupancy and highest non-empty level (level 0 wins)
    always_comb begin
        any_waiting = 1'b0;
        sel_lvl     = SYS_LEVEL;
        for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
            if (r_count[i] != '0) begin
                any_waiting = 1'b1;
                sel_lvl     = LVL_W'(i);
            end
        end
    end

    assign out_free   = !r_out_valid || !i_out_stall;
    assign rem_dec    = r_run_rem - 1'b1;
    assign demote_lvl = (r_run_lvl == TOP_LEVEL) ? TOP_LEVEL : r_run_lvl + 1'b1;

    // submit, tick with a running job, or idle tick
    always_comb begin
        w_push                = 1'b0;
        w_push_lvl            = r_req.job_level;
        w_push_entry          = {r_req.job_id, r_req.run_time};
        n_run_valid           = r_run_valid;
        n_run_rem             = r_run_rem;
        w_rsp.action          = ACT_IDLE;
        w_rsp.out_job_id      = '0;
        w_rsp.out_level       = '0;
        w_rsp.remaining_time  = '0;
        w_rsp.current_time    = r_time;
        if (r_req.req_type == REQ_SUBMIT) begin
            w_rsp.out_job_id     = r_req.job_id;
            w_rsp.out_level      = r_req.job_level;
            w_rsp.remaining_time = r_req.run_time;
            if (r_count[r_req.job_level] != FULL_CNT) begin
                w_push       = 1'b1;
                w_rsp.action = ACT_ACCEPT;
            end else begin
                w_rsp.action = ACT_REJECT;
            end
        end else if (r_run_valid) begin
            w_rsp.out_job_id = r_run_id;
            w_rsp.out_level  = r_run_lvl;
            if (r_run_rem <= TIME_W'(1)) begin
                n_run_valid  = 1'b0;
                n_run_rem    = '0;
                w_rsp.action = ACT_FINISH;
            end else begin
                n_run_rem            = rem_dec;
                w_rsp.remaining_time = rem_dec;
                w_rsp.action         = ACT_CONTINUE;
                // demote only when the lower queue has room
                if (any_waiting && (r_count[demote_lvl] != FULL_CNT)) begin
                    w_push          = 1'b1;
                    w_push_lvl      = demote_lvl;
                    w_push_entry    = {r_run_id, rem_dec};
                    n_run_valid     = 1'b0;
                    w_rsp.action    = ACT_PREEMPT;
                    w_rsp.out_level = demote_lvl;
                end
            end
        end else begin
            w_rsp.current_time = r_time + 1'b1;
        end
    end

    // dispatch of the queue head registered by the earlier head read
    assign pop_id = r_rd_data[ENTRY_W-1:TIME_W];
    assign pop_t  = r_rd_data[TIME_W-1:0];

    always_comb begin
        p_rsp.out_job_id = pop_id;
        if (r_pop_lvl == SYS_LEVEL) begin
            p_rsp.action         = ACT_SYSDONE;
            p_rsp.out_level      = SYS_LEVEL;
            p_rsp.remaining_time = '0;
            p_rsp.current_time   = r_time + CLK_W'(pop_t);
        end else begin
            p_rsp.action         = ACT_DISPATCH;
            p_rsp.out_level      = r_pop_lvl;
            p_rsp.remaining_time = pop_t;
            p_rsp.current_time   = r_time + 1'b1;
        end
    end

    // queue storage, one write and one registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && w_push) begin
            r_mem[{w_push_lvl, r_tail[w_push_lvl]}] <= w_push_entry;
        end
        if (i_cmd.read_head) begin
            r_rd_data <= r_mem[ADDR_W'({sel_lvl, r_head[sel_lvl]})];
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= i_in_req;
        end
        if (i_cmd.read_head) begin
            r_pop_lvl <= sel_lvl;
        end
        if (i_cmd.exec) begin
            r_out <= w_rsp;
        end else if (i_cmd.pop) begin
            r_out <= p_rsp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_LEVELS; i++) begin
                r_head[i]  <= '0;
                r_tail[i]  <= '0;
                r_count[i] <= '0;
            end
            r_run_valid <= 1'b0;
            r_run_id    <= '0;
            r_run_lvl   <= '0;
            r_run_rem   <= '0;
            r_time      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.exec) begin
                if (w_push) begin
                    r_tail[w_push_lvl]  <= ptr_inc(r_tail[w_push_lvl]);
                    r_count[w_push_lvl] <= r_count[w_push_lvl] + 1'b1;
                end
                r_run_valid <= n_run_valid;
                r_run_rem   <= n_run_rem;
                r_time      <= w_rsp.current_time;
            end
            if (i_cmd.pop) begin
                r_head[r_pop_lvl]  <= ptr_inc(r_head[r_pop_lvl]);
                r_count[r_pop_lvl] <= r_count[r_pop_lvl] - 1'b1;
                r_time             <= p_rsp.current_time;
                if (r_pop_lvl != SYS_LEVEL) begin
                    r_run_valid <= 1'b1;
                    r_run_id    <= pop_id;
                    r_run_lvl   <= r_pop_lvl;
                    r_run_rem   <= pop_t;
                end
            end
            if (i_cmd.exec || i_cmd.pop) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_status.is_tick     = (r_req.req_type == REQ_TICK);
    assign o_status.run_valid   = r_run_valid;
    assign o_status.any_waiting = any_waiting;
    assign o_status.out_free    = out_free;
    assign o_out_valid          = r_out_valid;
    assign o_out_rsp            = r_out;

    // every level's count within the queue depth
    always_comb begin
        count_ok = 1'b1;
        for (int i = 0; i < NUM_LEVELS; i++) begin
            if (r_count[i] > FULL_CNT) begin
                count_ok = 1'b0;
            end
        end
    end

    `FQD_ASSERT_ALWAYS(a_count_bound, count_ok, "queue count beyond depth")
    `FQD_ASSERT_IMPL(a_pop_nonempty, i_cmd.pop, r_count[r_pop_lvl] != '0, "pop from empty queue")
    `FQD_ASSERT_IMPL(a_no_overwrite, i_cmd.exec || i_cmd.pop, out_free, "result overwritten")
    `FQD_ASSERT_IMPL(a_read_when_free, i_cmd.read_head, !r_run_valid && any_waiting, "bad head read")
    `FQD_ASSERT_NEXT(a_dispatch_runs, i_cmd.pop && (r_pop_lvl != SYS_LEVEL), r_run_valid, "dispatch lost")

endmodule

// ===== rtl/fqd_ctrl.sv =====
// controller of the feedback queue dispatcher: sequences load, execute and queue pop
// depends on fqd_pkg
module fqd_ctrl import fqd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd,
    output logic       o_in_stall
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_POP
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                // dispatch needs the head entry first
                if (i_status.is_tick && !i_status.run_valid && i_status.any_waiting) begin
                    o_cmd.read_head = 1'b1;
                    n_state         = S_POP;
                end else if (i_status.out_free) begin
                    o_cmd.exec = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_POP: begin
                if (i_status.out_free) begin
                    o_cmd.pop = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

// ===== rtl/feedback_queue_dispatcher.sv =====
// top level of the four-level feedback queue dispatcher
// depends on fqd_pkg, fqd_ctrl and fqd_datapath
//
// Each request is either a job submit or one scheduler tick, and gives exactly
// one result. A submit puts {id, run time} at the tail of its level's queue,
// or is rejected if that queue holds QUEUE_DEPTH jobs. A tick counts down the
// running job; when it runs out the job finishes, otherwise if anything waits
// it is preempted and requeued one level lower (level 3 stays at 3), unless
// that queue is full, in which case it simply continues. With nothing running
// a tick pops the head of the highest non-empty level: a level 0 job completes
// at once and advances the time counter by its run time, any other job starts
// running and the counter advances by one; an empty tick also advances by one.
// A request is captured in S_IDLE and executed in S_EXEC. A tick that
// dispatches from a queue instead does a registered read of the queue
// memory head in S_EXEC and pops it in S_POP. The result sits in an
// output register, so the next request is taken while it waits; a stalled
// output only holds the block once the following result is ready to go.
// Queue memory is not cleared after reset: counts guard every read.
module feedback_queue_dispatcher import fqd_pkg::*; #(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    // request channel
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_in_req  i_in_req,
    // result channel
    output logic     o_out_valid,
    input  logic     i_out_stall,
    output t_out_rsp o_out_rsp
);

    t_dp_cmd    cmd;
    t_dp_status status;

    // sequencing of each request
    fqd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    // queues, running job, time counter and result register
    fqd_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_req    (i_in_req),
        .i_cmd       (cmd),
        .i_out_stall (i_out_stall),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .o_out_rsp   (o_out_rsp)
    );

endmodule

// ===== test/tb_feedback_queue_dispatcher.sv =====
// self-checking testbench for the four-level feedback queue dispatcher
// depends on fqd_pkg and the feedback_queue_dispatcher rtl; a scoreboard class
// predicts every result and compares it with what the block returns

class dispatch_scoreboard;

    localparam int DEPTH = fqd_pkg::DEF_QUEUE_DEPTH;

    // per-level job queues, each slot holds {id, time}
    logic [fqd_pkg::ENTRY_W-1:0] slots [fqd_pkg::NUM_LEVELS][DEPTH];
    int unsigned head  [fqd_pkg::NUM_LEVELS];
    int unsigned count [fqd_pkg::NUM_LEVELS];

    bit                                busy;
    logic [fqd_pkg::ID_W-1:0]          cur_id;
    logic [fqd_pkg::LVL_W-1:0]         cur_level;
    logic [fqd_pkg::TIME_W-1:0]        cur_left;
    logic [fqd_pkg::CLK_W-1:0]         clock_count;

    fqd_pkg::t_out_rsp expected [$];
    int                mismatches;
    int                checked;

    function new();
        foreach (head[i]) begin
            head[i]  = 0;
            count[i] = 0;
        end
        busy        = 1'b0;
        cur_id      = '0;
        cur_level   = '0;
        cur_left    = '0;
        clock_count = '0;
        mismatches  = 0;
        checked     = 0;
    endfunction

    function bit push_job(logic [fqd_pkg::LVL_W-1:0] lvl, logic [fqd_pkg::ID_W-1:0] id,
                          logic [fqd_pkg::TIME_W-1:0] t);
        if (count[lvl] >= DEPTH)
            return 1'b0;
        slots[lvl][(head[lvl] + count[lvl]) % DEPTH] = {id, t};
        count[lvl]++;
        return 1'b1;
    endfunction

    function bit anyone_waiting();
        foreach (count[i])
            if (count[i] != 0)
                return 1'b1;
        return 1'b0;
    endfunction

    function fqd_pkg::t_out_rsp result(fqd_pkg::t_action act, logic [fqd_pkg::ID_W-1:0] id,
                                       logic [fqd_pkg::LVL_W-1:0] lvl,
                                       logic [fqd_pkg::TIME_W-1:0] rem);
        fqd_pkg::t_out_rsp rsp;
        rsp.action         = act;
        rsp.out_job_id     = id;
        rsp.out_level      = lvl;
        rsp.remaining_time = rem;
        rsp.current_time   = clock_count;
        return rsp;
    endfunction

    // work out the result of one accepted request and queue it
    function void note_request(fqd_pkg::t_in_req r);
        fqd_pkg::t_out_rsp           rsp;
        logic [fqd_pkg::LVL_W-1:0]   next_level;
        logic [fqd_pkg::ENTRY_W-1:0] slot;
        int                          lvl;
        if (r.req_type == fqd_pkg::REQ_SUBMIT) begin
            if (push_job(r.job_level, r.job_id, r.run_time))
                rsp = result(fqd_pkg::ACT_ACCEPT, r.job_id, r.job_level, r.run_time);
            else
                rsp = result(fqd_pkg::ACT_REJECT, r.job_id, r.job_level, r.run_time);
        end else if (busy) begin
            if (cur_left <= 1) begin
                busy     = 1'b0;
                cur_left = '0;
                rsp = result(fqd_pkg::ACT_FINISH, cur_id, cur_level, '0);
            end else begin
                cur_left--;
                next_level = (cur_level < fqd_pkg::TOP_LEVEL) ? cur_level + 2'd1
                                                               : fqd_pkg::TOP_LEVEL;
                if (anyone_waiting() && push_job(next_level, cur_id, cur_left)) begin
                    busy = 1'b0;
                    rsp = result(fqd_pkg::ACT_PREEMPT, cur_id, next_level, cur_left);
                end else begin
                    rsp = result(fqd_pkg::ACT_CONTINUE, cur_id, cur_level, cur_left);
                end
            end
        end else begin
            lvl = 0;
            while (lvl < fqd_pkg::NUM_LEVELS && count[lvl] == 0)
                lvl++;
            if (lvl == fqd_pkg::NUM_LEVELS) begin
                clock_count += 1;
                rsp = result(fqd_pkg::ACT_IDLE, '0, '0, '0);
            end else begin
                slot       = slots[lvl][head[lvl]];
                head[lvl]  = (head[lvl] + 1) % DEPTH;
                count[lvl]--;
                if (lvl == fqd_pkg::SYS_LEVEL) begin
                    clock_count += 32'(slot[fqd_pkg::TIME_W-1:0]);
                    rsp = result(fqd_pkg::ACT_SYSDONE, slot[fqd_pkg::ENTRY_W-1:fqd_pkg::TIME_W],
                                 fqd_pkg::SYS_LEVEL, '0);
                end else begin
                    busy      = 1'b1;
                    cur_id    = slot[fqd_pkg::ENTRY_W-1:fqd_pkg::TIME_W];
                    cur_level = lvl[fqd_pkg::LVL_W-1:0];
                    cur_left  = slot[fqd_pkg::TIME_W-1:0];
                    clock_count += 1;
                    rsp = result(fqd_pkg::ACT_DISPATCH, cur_id, cur_level, cur_left);
                end
            end
        end
        expected.push_back(rsp);
    endfunction

    function void check_result(fqd_pkg::t_out_rsp got);
        fqd_pkg::t_out_rsp want;
        checked++;
        if (expected.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("result %0d with nothing pending: act=%0d id=%0d lvl=%0d rem=%0d clk=%0d",
                         checked, got.action, got.out_job_id, got.out_level,
                         got.remaining_time, got.current_time);
            return;
        end
        want = expected.pop_front();
        if (got.action !== want.action || got.out_job_id !== want.out_job_id ||
            got.out_level !== want.out_level || got.remaining_time !== want.remaining_time ||
            got.current_time !== want.current_time) begin
            mismatches++;
            if (mismatches <= 10) begin
                $write("result %0d: expected act=%0d id=%0d lvl=%0d rem=%0d clk=%0d,",
                       checked, want.action, want.out_job_id, want.out_level,
                       want.remaining_time, want.current_time);
                $display(" got act=%0d id=%0d lvl=%0d rem=%0d clk=%0d",
                         got.action, got.out_job_id, got.out_level,
                         got.remaining_time, got.current_time);
            end
        end
    endfunction

endclass

module tb_feedback_queue_dispatcher;
    import fqd_pkg::*;

    localparam int DEPTH = DEF_QUEUE_DEPTH;

    logic     i_clk       = 1'b0;
    logic     i_rst_n     = 1'b0;
    logic     i_in_valid  = 1'b0;
    t_in_req  i_in_req    = '0;
    logic     i_out_stall = 1'b0;
    logic     o_in_stall;
    logic     o_out_valid;
    t_out_rsp o_out_rsp;

    dispatch_scoreboard sb = new();

    // when set, neither side inserts gaps or stalls
    bit calm       = 1'b0;
    int stall_left = 0;

    feedback_queue_dispatcher #(
        .QUEUE_DEPTH (DEPTH)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_req    (i_in_req),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_rsp   (o_out_rsp)
    );

    always #5 i_clk = ~i_clk;

    // result side: check each accepted result, then hold stall for a random
    // number of cycles; stall also runs while nothing is valid, so the gaps
    // land on every phase of the block's work
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            sb.check_result(o_out_rsp);
            stall_left = calm ? 0 : $urandom_range(0, 3);
        end
        if (stall_left != 0) begin
            i_out_stall <= 1'b1;
            stall_left--;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // hand one request over, after a random gap, and note it once it is taken
    task automatic send_request(input t_in_req r);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 3);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_req   <= r;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_request(r);
    endtask

    task automatic submit_job(input logic [ID_W-1:0] id, input logic [LVL_W-1:0] lvl,
                              input logic [TIME_W-1:0] t);
        t_in_req r;
        r.req_type  = REQ_SUBMIT;
        r.job_id    = id;
        r.job_level = lvl;
        r.run_time  = t;
        send_request(r);
    endtask

    // job fields are ignored on a tick but still carry random bits
    task automatic tick();
        t_in_req r;
        r.req_type  = REQ_TICK;
        r.job_id    = ID_W'($urandom_range(0, 255));
        r.job_level = LVL_W'($urandom_range(0, 3));
        r.run_time  = TIME_W'($urandom_range(0, 65535));
        send_request(r);
    endtask

    // mostly short jobs so the queues keep moving, a few long and huge ones
    function automatic logic [TIME_W-1:0] draw_run_time();
        case ($urandom_range(0, 9))
            0:       return TIME_W'($urandom_range(0, 65535));
            1, 2:    return TIME_W'($urandom_range(7, 40));
            default: return TIME_W'($urandom_range(0, 6));
        endcase
    endfunction

    // lower valid and wait until every outstanding request has its result
    task automatic drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.expected.size() != 0);
    endtask

    initial begin
        int submit_pct;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // idle tick on an empty block
        tick();
        // system job with all-ones id and run time completes at once
        submit_job(8'hFF, SYS_LEVEL, 16'hFFFF);
        tick();
        // zero run time system job adds nothing to the clock
        submit_job(8'h00, SYS_LEVEL, 16'h0000);
        tick();
        // level 2 job gets dispatched
        submit_job(8'h5A, 2'd2, 16'd5);
        tick();
        // fill the lowest level, then one more is rejected
        for (int i = 0; i < DEPTH; i++)
            submit_job(ID_W'(8'h30 + i), TOP_LEVEL, TIME_W'((i % 4) + 1));
        submit_job(8'hA5, TOP_LEVEL, 16'h1234);
        // demotion target full: the running job keeps going at level 2
        tick();
        tick();

        // random part in phases of varying submit/tick mix
        for (int phase = 0; phase < 8; phase++) begin
            calm = (phase == 2 || phase == 6);
            // pause the requests once until everything has come back
            if (phase == 4)
                drain();
            case ($urandom_range(0, 2))
                0:       submit_pct = 25;
                1:       submit_pct = 50;
                default: submit_pct = 80;
            endcase
            for (int n = 0; n < 50; n++) begin
                if ($urandom_range(1, 100) <= submit_pct)
                    submit_job(ID_W'($urandom_range(0, 255)), LVL_W'($urandom_range(0, 3)),
                               draw_run_time());
                else
                    tick();
            end
        end
        calm = 1'b0;

        drain();
        repeat (20) @(posedge i_clk);

        if (sb.mismatches == 0 && sb.expected.size() == 0)
            $display("feedback_queue_dispatcher: match");
        else
            $display("feedback_queue_dispatcher: mismatch");
        $finish;
    end

    // run limit, far beyond the slowest correct run
    initial begin
        #1000000;
        $display("feedback_queue_dispatcher: mismatch");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/fqd_pkg.sv
rtl/fqd_datapath.sv
rtl/fqd_ctrl.sv
rtl/feedback_queue_dispatcher.sv
test/tb_feedback_queue_dispatcher.sv
